// ===== hw/rtl/fmd_pkg.sv =====
// Shared types, constants and the ring classification function of the minutiae detector.
`timescale 1ns / 1ps
`default_nettype none

package fmd_pkg;

	// Line store depth and position widths.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Field widths of the transactions and registers.
	localparam int GRAY_W  = 8;
	localparam int DIM_W   = 11;
	localparam int POS_W   = 10;
	localparam int TOTAL_W = 16;
	localparam int CFG_W   = 11;
	localparam int IDX_W   = 2;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd2;

	// Register reset values.
	localparam logic [GRAY_W-1:0] THRESHOLD_RESET = 8'd100;
	localparam logic [DIM_W-1:0]  WIDTH_RESET     = 11'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RESET    = 11'd480;
	localparam logic [DIM_W-1:0]  DIM_MIN         = 11'd3;

	// Neighbor counts that mark a minutia, and the kind codes.
	localparam logic [3:0] COUNT_BIFURCATION = 4'd5;
	localparam logic [3:0] COUNT_TERMINATION = 4'd7;
	localparam logic       KIND_BIFURCATION  = 1'b0;
	localparam logic       KIND_TERMINATION  = 1'b1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Depth of the result queue in front of the output port.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// One window column: bit 0 top row, bit 1 middle row, bit 2 bottom row.
	typedef logic [2:0] col_t;

	typedef struct packed {
		logic [GRAY_W-1:0] gray_pixel;
		logic              frame_start;
	} pix_t;

	typedef struct packed {
		logic [POS_W-1:0]   minutia_x;
		logic [POS_W-1:0]   minutia_y;
		logic               minutia_kind;
		logic [TOTAL_W-1:0] minutia_total;
	} mnt_t;

	// Walk the eight neighbors clockwise from the top-left one. Every neighbor counts
	// unless it is black and the next one is white, so the count is eight minus the
	// number of black-to-white steps around the ring.
	function automatic logic [3:0] ring_count(input col_t left, input col_t mid,
		input col_t right);
		logic [7:0] ring;
		logic [3:0] cnt;
		ring = {left[1], left[2], mid[2], right[2], right[1], right[0], mid[0], left[0]};
		cnt  = 4'd8;
		for (int k = 0; k < 8; k++) begin
			if (!ring[k] && ring[(k + 1) % 8])
				cnt = cnt - 4'd1;
		end
		return cnt;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fmd_if.sv =====
// Valid/ready stream interfaces for the pixel input and the minutia output.
`timescale 1ns / 1ps
`default_nettype none

interface fmd_pix_if;
	logic          valid;
	logic          ready;
	fmd_pkg::pix_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fmd_mnt_if;
	logic          valid;
	logic          ready;
	fmd_pkg::mnt_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fmd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fmd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fmd_cell.sv =====
// One column cell of the 3x3 window chain; it takes its neighbor's column on each shift.
`timescale 1ns / 1ps
`default_nettype none

module fmd_cell (
	input  wire logic          clk,
	input  wire logic          shift,
	input  wire fmd_pkg::col_t col_in,
	output fmd_pkg::col_t      col_out
);

	fmd_pkg::col_t col_q;

	always_ff @(posedge clk) begin
		if (shift)
			col_q <= col_in;
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fingerprint_minutiae_detector.sv =====
// Top level of the minutiae detector: position tracking, line store, window chain, results.
// A minutia passes stage 1, stage 2 and the result queue on its way from its completing pixel to the output port.
// Throughput: one pixel per cycle unless clearing or the four-entry result queue fills; it absorbs output stalls.
// The pixel rate is set by the line store, read once and written once per pixel.
// Reset is asynchronous; after it a pass clears all 1024 line store entries,
// during which no pixel is accepted (configuration writes are taken).
`timescale 1ns / 1ps
`default_nettype none

module fingerprint_minutiae_detector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	fmd_pix_if.sink                          pixels,
	fmd_mnt_if.source                        minutiae,
	input  wire logic                        cfg_we,
	input  wire logic [fmd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [fmd_pkg::CFG_W-1:0]   cfg_data
);

	localparam int COL_W   = fmd_pkg::COL_W;
	localparam int ROW_W   = fmd_pkg::ROW_W;
	localparam int DIM_W   = fmd_pkg::DIM_W;
	localparam int TOTAL_W = fmd_pkg::TOTAL_W;
	localparam int FAW     = fmd_pkg::FIFO_AW;

	// ------------------------------------------------------------------
	// Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
	// ------------------------------------------------------------------
	logic [fmd_pkg::GRAY_W-1:0] thresh_q;
	logic [DIM_W-1:0]           width_q;
	logic [DIM_W-1:0]           height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= fmd_pkg::THRESHOLD_RESET;
			width_q  <= fmd_pkg::WIDTH_RESET;
			height_q <= fmd_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fmd_pkg::REG_THRESHOLD: thresh_q <= cfg_data[fmd_pkg::GRAY_W-1:0];
				fmd_pkg::REG_WIDTH:     width_q  <= cfg_data;
				fmd_pkg::REG_HEIGHT:    height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame size clamped to the range the hardware supports.
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	always_comb begin
		if (width_q < fmd_pkg::DIM_MIN)
			w_eff = fmd_pkg::DIM_MIN;
		else if (width_q > DIM_W'(fmd_pkg::MAX_WIDTH))
			w_eff = DIM_W'(fmd_pkg::MAX_WIDTH);
		else
			w_eff = width_q;

		if (height_q < fmd_pkg::DIM_MIN)
			h_eff = fmd_pkg::DIM_MIN;
		else if (height_q > DIM_W'(fmd_pkg::MAX_HEIGHT))
			h_eff = DIM_W'(fmd_pkg::MAX_HEIGHT);
		else
			h_eff = height_q;
	end

	// ------------------------------------------------------------------
	// Line store clearing pass after reset. The store starts out all black,
	// which matters when the frame width is raised in the middle of a frame.
	// ------------------------------------------------------------------
	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + COL_W'(1);
			if (clr_addr_q == COL_W'(fmd_pkg::MAX_WIDTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Flow control. Every accepted pixel yields at most one result, so a pixel is
	// taken only while the queue has room for everything already in flight.
	// ------------------------------------------------------------------
	logic           v_s1;
	logic           v_s2;
	logic [FAW:0]   fifo_cnt_q;
	logic [FAW:0]   in_flight;
	logic           pix_acc;

	assign in_flight    = fifo_cnt_q + {{FAW{1'b0}}, v_s1} + {{FAW{1'b0}}, v_s2};
	assign pixels.ready = !clr_busy_q && (in_flight < (FAW + 1)'(fmd_pkg::FIFO_DEPTH));
	assign pix_acc      = pixels.valid && pixels.ready;

	// ------------------------------------------------------------------
	// Stage 0: position of the incoming pixel, binarization, line store read.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_base;
	logic [ROW_W-1:0] row_base;
	logic [COL_W-1:0] col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [COL_W-1:0] col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             out_of_frame;
	logic             white;

	always_comb begin
		col_base = pixels.payload.frame_start ? '0 : col_q;
		row_base = pixels.payload.frame_start ? '0 : row_q;
		// A position past the frame (end of frame or a shrunken size) wraps to the origin.
		out_of_frame = (DIM_W'(col_base) >= w_eff) || (DIM_W'(row_base) >= h_eff);
		col_cur = out_of_frame ? '0 : col_base;
		row_cur = out_of_frame ? '0 : row_base;

		col_inc = DIM_W'(col_cur) + DIM_W'(1);
		row_inc = DIM_W'(row_cur) + DIM_W'(1);
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			row_nxt = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
		end else begin
			col_nxt = COL_W'(col_inc);
			row_nxt = row_cur;
		end

		white = pixels.payload.gray_pixel > thresh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the line store word arrives; it holds the two earlier rows at this
	// column (bit 1 upper, bit 0 middle). The window chain shifts in the new column
	// and the store is written back with the rows moved up by one.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic             white_s1;
	logic             fs_s1;
	logic [1:0]       lines_rd;
	logic [1:0]       lines_cur;
	logic             byp_s1;
	logic [1:0]       byp_data_s1;
	logic             ram_we;
	logic [COL_W-1:0] ram_waddr;
	logic [1:0]       ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= pix_acc;
	end

	// Two pixels in a row can land on the same column (a frame start right after
	// column zero). The store read then misses the write of the pixel ahead, so
	// that write is captured here and used in place of the read data.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			c_s1        <= col_cur;
			r_s1        <= row_cur;
			white_s1    <= white;
			fs_s1       <= pixels.payload.frame_start;
			byp_s1      <= v_s1 && (c_s1 == col_cur);
			byp_data_s1 <= ram_wdata;
		end
	end

	assign lines_cur = byp_s1 ? byp_data_s1 : lines_rd;

	assign ram_we    = clr_busy_q || v_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : c_s1;
	assign ram_wdata = clr_busy_q ? 2'b00 : {lines_cur[0], white_s1};

	fmd_ram #(
		.WIDTH (2),
		.DEPTH (fmd_pkg::MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pix_acc),
		.raddr (col_cur),
		.rdata (lines_rd)
	);

	// Window chain: the right cell takes the new column, the others take their
	// neighbor's column, so the left cell holds the oldest column.
	fmd_pkg::col_t col_new;
	fmd_pkg::col_t win_right;
	fmd_pkg::col_t win_mid;
	fmd_pkg::col_t win_left;

	assign col_new = {white_s1, lines_cur[0], lines_cur[1]};

	fmd_cell u_cell_right (
		.clk     (clk),
		.shift   (v_s1),
		.col_in  (col_new),
		.col_out (win_right)
	);

	fmd_cell u_cell_mid (
		.clk     (clk),
		.shift   (v_s1),
		.col_in  (win_right),
		.col_out (win_mid)
	);

	fmd_cell u_cell_left (
		.clk     (clk),
		.shift   (v_s1),
		.col_in  (win_mid),
		.col_out (win_left)
	);

	// ------------------------------------------------------------------
	// Stage 2: the chain now holds this pixel's window. A black interior center is
	// classified by its ring count and the frame's running total is advanced.
	// ------------------------------------------------------------------
	logic [COL_W-1:0]   c_s2;
	logic [ROW_W-1:0]   r_s2;
	logic               fs_s2;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_base;
	logic [TOTAL_W-1:0] total_new;
	logic [3:0]         ring_cnt;
	logic               interior;
	logic               hit_s2;
	fmd_pkg::mnt_t      result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			c_s2  <= c_s1;
			r_s2  <= r_s1;
			fs_s2 <= fs_s1;
		end
	end

	always_comb begin
		ring_cnt   = fmd_pkg::ring_count(win_left, win_mid, win_right);
		interior   = (c_s2 >= COL_W'(2)) && (r_s2 >= ROW_W'(2)) && !win_mid[1];
		hit_s2     = v_s2 && interior && (ring_cnt == fmd_pkg::COUNT_BIFURCATION ||
			ring_cnt == fmd_pkg::COUNT_TERMINATION);
		total_base = fs_s2 ? '0 : total_q;
		total_new  = (total_base == fmd_pkg::TOTAL_MAX) ? total_base :
			total_base + TOTAL_W'(1);

		result.minutia_x     = fmd_pkg::POS_W'(c_s2 - COL_W'(1));
		result.minutia_y     = fmd_pkg::POS_W'(r_s2 - ROW_W'(1));
		result.minutia_kind  = (ring_cnt == fmd_pkg::COUNT_TERMINATION) ?
			fmd_pkg::KIND_TERMINATION : fmd_pkg::KIND_BIFURCATION;
		result.minutia_total = total_new;
	end

	// The total survives the end of a frame and is cleared only by a frame start or a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= '0;
		else if (v_s2)
			total_q <= hit_s2 ? total_new : total_base;
	end

	// ------------------------------------------------------------------
	// Result queue: parts the pipeline from the consumer so the pipeline never
	// stalls once a pixel is accepted.
	// ------------------------------------------------------------------
	fmd_pkg::mnt_t  fifo_q [fmd_pkg::FIFO_DEPTH];
	logic [FAW-1:0] wr_ptr_q;
	logic [FAW-1:0] rd_ptr_q;
	logic           pop;

	assign pop              = minutiae.valid && minutiae.ready;
	assign minutiae.valid   = fifo_cnt_q != '0;
	assign minutiae.payload = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (hit_s2)
			fifo_q[wr_ptr_q] <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (hit_s2)
				wr_ptr_q <= wr_ptr_q + FAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FAW'(1);
			if (hit_s2 && !pop)
				fifo_cnt_q <= fifo_cnt_q + (FAW + 1)'(1);
			else if (pop && !hit_s2)
				fifo_cnt_q <= fifo_cnt_q - (FAW + 1)'(1);
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// Queue entries plus pixels in the pipeline never exceed the queue depth.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= (FAW + 1)'(fmd_pkg::FIFO_DEPTH))
		else $error("result queue reservation exceeded");

	// A new result never lands in a full queue without a departure.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s2 |-> (fifo_cnt_q != (FAW + 1)'(fmd_pkg::FIFO_DEPTH)) || pop)
		else $error("result queue overflow");

	// The clearing pass owns the line store write port alone.
	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s1 && !v_s2)
		else $error("pixel in flight during line store clearing");

	// Every reported minutia has been counted in the frame total.
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		minutiae.valid |-> minutiae.payload.minutia_total != '0)
		else $error("minutia reported with zero total");

endmodule

`default_nettype wire
